/* sv/stt_pkg.sv */
// shared types and character codes for the source text tokenizer
package stt_pkg;

  localparam int OUT_LINE_W = 24;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNMATCHED = 3'd1,
    ST_UNCLOSED  = 3'd2,
    ST_STRING    = 3'd3,
    ST_PENDING   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;

  // words produced by one input byte, in delivery order tok0, tok1, stat
  typedef struct packed {
    logic                  tok0_valid;
    logic [7:0]            tok0_byte;
    logic                  tok0_first;
    logic                  tok1_valid;
    logic [7:0]            tok1_byte;
    logic                  tok1_first;
    logic [OUT_LINE_W-1:0] tok_line;
    logic                  stat_valid;
    status_t               stat_code;
    logic [OUT_LINE_W-1:0] stat_line;
    logic                  stat_use_top;
  } group_t;

endpackage

/* sv/stt_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/stt_lexer.sv */
// lexer state, per-byte mode update and bracket stack access
module stt_lexer #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_WIDTH = 24,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            c,
  input  logic                  last,
  output stt_pkg::group_t       grp,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [LINE_WIDTH-1:0] ram_wdata,
  output logic                  ram_re,
  output logic [AW-1:0]         ram_raddr
);
  import stt_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    M_NORMAL, M_OPWAIT, M_SLASH, M_LINECOM, M_BLOCKCOM, M_STRING
  } mode_t;

  mode_t                 mode, mode_next;
  logic                  token_open, open_next;
  logic                  quote_char, quote_next;
  logic                  star_seen, star_next;
  logic [LINE_WIDTH-1:0] line_count, line_next;
  logic [SP_W-1:0]       stack_pointer, sp_next, sp_dec;
  status_t               error_code, err_next;
  logic [LINE_WIDTH-1:0] error_line, errl_next;
  logic                  run_normal;
  logic                  push;
  logic [7:0]            qch;

  function automatic logic [OUT_LINE_W-1:0] to_out(input logic [LINE_WIDTH-1:0] v);
    logic [LINE_WIDTH+OUT_LINE_W-1:0] ext;
    ext = {{OUT_LINE_W{1'b0}}, v};
    return ext[OUT_LINE_W-1:0];
  endfunction

  assign qch = quote_char ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    mode_next  = mode;
    open_next  = token_open;
    quote_next = quote_char;
    star_next  = star_seen;
    line_next  = line_count;
    sp_next    = stack_pointer;
    err_next   = error_code;
    errl_next  = error_line;
    run_normal = 1'b0;
    push       = 1'b0;
    grp        = '0;
    grp.tok_line = to_out(line_count);

    case (mode)
      M_OPWAIT: begin
        mode_next = M_NORMAL;
        if (c == CH_EQ) begin
          grp.tok1_valid = 1'b1;
          grp.tok1_byte  = c;
        end else begin
          run_normal = 1'b1;
        end
      end
      M_SLASH: begin
        if (c == CH_SLASH) begin
          mode_next = M_LINECOM;
        end else if (c == CH_STAR) begin
          mode_next = M_BLOCKCOM;
          star_next = 1'b1;
        end else begin
          mode_next = M_NORMAL;
          grp.tok0_valid = 1'b1;
          grp.tok0_byte  = CH_SLASH;
          grp.tok0_first = 1'b1;
          run_normal = 1'b1;
        end
      end
      M_LINECOM: begin
        if (c == CH_NL) begin
          if (~&line_next) line_next = line_next + LINE_WIDTH'(1);
          mode_next = M_NORMAL;
        end
      end
      M_BLOCKCOM: begin
        if (star_seen && c == CH_SLASH) begin
          mode_next = M_NORMAL;
          star_next = 1'b0;
        end else begin
          star_next = (c == CH_STAR);
          if (c == CH_NL && ~&line_next) line_next = line_next + LINE_WIDTH'(1);
        end
      end
      M_STRING: begin
        if (c == CH_NL) begin
          if (err_next == ST_OK) begin
            err_next  = ST_STRING;
            errl_next = line_count;
          end
          mode_next  = M_NORMAL;
          open_next  = 1'b0;
          run_normal = 1'b1;
        end else begin
          grp.tok1_valid = 1'b1;
          grp.tok1_byte  = c;
          if (c == qch) begin
            open_next = 1'b0;
            mode_next = M_NORMAL;
          end
        end
      end
      default: begin
        mode_next  = M_NORMAL;
        run_normal = 1'b1;
      end
    endcase

    if (run_normal) begin
      case (c) inside
        CH_LPAREN, CH_LBRACK, CH_LBRACE: begin
          if (sp_next < SP_W'(STACK_DEPTH)) begin
            push    = 1'b1;
            sp_next = sp_next + SP_W'(1);
          end else if (err_next == ST_OK) begin
            err_next  = ST_FULL;
            errl_next = line_count;
          end
          grp.tok1_valid = 1'b1;
          grp.tok1_byte  = c;
          grp.tok1_first = 1'b1;
          open_next = 1'b0;
        end
        CH_RPAREN, CH_RBRACK, CH_RBRACE: begin
          if (sp_next == '0) begin
            if (err_next == ST_OK) begin
              err_next  = ST_UNMATCHED;
              errl_next = line_count;
            end
          end else begin
            sp_next = sp_next - SP_W'(1);
          end
          grp.tok1_valid = 1'b1;
          grp.tok1_byte  = c;
          grp.tok1_first = 1'b1;
          open_next = 1'b0;
        end
        CH_LT, CH_GT, CH_BANG, CH_EQ: begin
          grp.tok1_valid = 1'b1;
          grp.tok1_byte  = c;
          grp.tok1_first = 1'b1;
          open_next = 1'b0;
          mode_next = M_OPWAIT;
        end
        CH_DQUOTE, CH_SQUOTE: begin
          grp.tok1_valid = 1'b1;
          grp.tok1_byte  = c;
          grp.tok1_first = ~open_next;
          open_next  = 1'b1;
          quote_next = (c == CH_SQUOTE);
          mode_next  = M_STRING;
        end
        CH_SLASH: begin
          open_next = 1'b0;
          mode_next = M_SLASH;
        end
        CH_SPACE, CH_TAB: begin
          open_next = 1'b0;
        end
        CH_NL: begin
          open_next = 1'b0;
          if (~&line_next) line_next = line_next + LINE_WIDTH'(1);
        end
        CH_COMMA, CH_SEMI, CH_MINUS, CH_PLUS, CH_STAR, CH_PERCENT: begin
          grp.tok1_valid = 1'b1;
          grp.tok1_byte  = c;
          grp.tok1_first = 1'b1;
          open_next = 1'b0;
        end
        default: begin
          grp.tok1_valid = 1'b1;
          grp.tok1_byte  = c;
          grp.tok1_first = ~open_next;
          open_next = 1'b1;
        end
      endcase
    end

    sp_dec = sp_next - SP_W'(1);

    if (last) begin
      grp.stat_valid = 1'b1;
      if (err_next != ST_OK) begin
        grp.stat_code = err_next;
        grp.stat_line = to_out(errl_next);
      end else begin
        grp.stat_line = to_out(line_next);
        if (mode_next == M_STRING) begin
          grp.stat_code = ST_STRING;
        end else if (mode_next != M_NORMAL) begin
          grp.stat_code = ST_PENDING;
        end else if (sp_next != '0) begin
          grp.stat_code = ST_UNCLOSED;
          // a bracket opened by this very byte is not yet in the ram
          if (push) begin
            grp.stat_line = to_out(line_count);
          end else begin
            grp.stat_use_top = 1'b1;
          end
        end else begin
          grp.stat_code = ST_OK;
        end
      end
      mode_next  = M_NORMAL;
      open_next  = 1'b0;
      quote_next = 1'b0;
      star_next  = 1'b0;
      line_next  = LINE_WIDTH'(1);
      sp_next    = '0;
      err_next   = ST_OK;
      errl_next  = '0;
    end
  end

  assign ram_we    = fire & push;
  assign ram_waddr = stack_pointer[AW-1:0];
  assign ram_wdata = line_count;
  assign ram_re    = fire & grp.stat_use_top;
  assign ram_raddr = sp_dec[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_NORMAL;
      token_open    <= 1'b0;
      quote_char    <= 1'b0;
      star_seen     <= 1'b0;
      line_count    <= LINE_WIDTH'(1);
      stack_pointer <= '0;
      error_code    <= ST_OK;
      error_line    <= '0;
    end else if (fire) begin
      mode          <= mode_next;
      token_open    <= open_next;
      quote_char    <= quote_next;
      star_seen     <= star_next;
      line_count    <= line_next;
      stack_pointer <= sp_next;
      error_code    <= err_next;
      error_line    <= errl_next;
    end
  end

endmodule

/* sv/stt_out.sv */
// output word buffer that delivers the words of one byte in order
module stt_out #(
  parameter int LINE_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  stt_pkg::group_t       grp_in,
  input  logic [LINE_WIDTH-1:0] top_line,
  output logic                  ready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,
  output logic [0:0]            m_tuser,
  output logic                  m_tlast
);
  import stt_pkg::*;

  group_t                grp;
  logic [2:0]            pend;
  logic [2:0]            pend_rest;
  logic                  lone;
  logic [7:0]            byte_sel;
  logic                  first_sel;
  logic [OUT_LINE_W-1:0] line_sel;
  status_t               status_sel;

  function automatic logic [OUT_LINE_W-1:0] to_out(input logic [LINE_WIDTH-1:0] v);
    logic [LINE_WIDTH+OUT_LINE_W-1:0] ext;
    ext = {{OUT_LINE_W{1'b0}}, v};
    return ext[OUT_LINE_W-1:0];
  endfunction

  assign pend_rest = pend & (pend - 3'd1);
  assign lone      = (pend_rest == 3'd0);
  assign ready     = lone & (~|pend | m_tready);

  always_comb begin
    byte_sel   = '0;
    first_sel  = 1'b0;
    line_sel   = grp.tok_line;
    status_sel = ST_OK;
    m_tuser    = 1'b0;
    if (pend[0]) begin
      byte_sel  = grp.tok0_byte;
      first_sel = grp.tok0_first;
    end else if (pend[1]) begin
      byte_sel  = grp.tok1_byte;
      first_sel = grp.tok1_first;
    end else begin
      m_tuser    = 1'b1;
      status_sel = grp.stat_code;
      line_sel   = grp.stat_use_top ? to_out(top_line) : grp.stat_line;
    end
  end

  assign m_tvalid = |pend;
  assign m_tlast  = lone;
  assign m_tdata  = {4'b0, status_sel, line_sel, first_sel, byte_sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load) begin
      pend <= {grp_in.stat_valid, grp_in.tok1_valid, grp_in.tok0_valid};
    end else if (m_tvalid && m_tready) begin
      pend <= pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

endmodule

/* sv/source_text_tokenizer.sv */
// top level of the source text tokenizer
// Takes one byte of source text per word and gives back the kept bytes as token words,
// each marked as the first of a token or not and tagged with its line, then one status
// word after the byte marked by tlast. Unless the output stalls, a byte that yields at most
// one word is taken every cycle; a byte that yields two or three words (a slash followed by
// a token byte, the final byte with its status) holds the input until only its last word is
// left, as the output buffer hands out one word per cycle. Open-bracket lines are kept in a
// stack ram of STACK_DEPTH entries; the line of the innermost open bracket is read from it
// in the cycle after the final byte and goes straight into that byte's status word. Stack
// entries are only read below the stack pointer, so the ram needs no clearing after reset.
module source_text_tokenizer #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_byte, first_of_token, line_number, status, zero fill
  output logic [0:0]  m_tuser,   // kind
  output logic        m_tlast    // last_of_run
);
  import stt_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic                  fire;
  group_t                grp;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [LINE_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [LINE_WIDTH-1:0] ram_rdata;

  assign fire = s_tvalid & s_tready;

  stt_lexer #(
    .STACK_DEPTH(STACK_DEPTH),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_lexer (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .c        (s_tdata),
    .last     (s_tlast),
    .grp      (grp),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr)
  );

  stt_ram #(
    .WIDTH(LINE_WIDTH),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  stt_out #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (fire),
    .grp_in  (grp),
    .top_line(ram_rdata),
    .ready   (s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

/* sv/stt_checker.sv */
// port-level checks for the source text tokenizer and their binding
module stt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output word changed while stalled");

  // the status word always closes its run
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("status word not last of run");

  // status word carries no byte and no token mark
  a_status_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[8:0] == 9'd0)
    else $error("status word carries token data");

  // token words carry a zero status and zero fill
  a_token_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[39:33] == 7'd0)
    else $error("token word carries status bits");

  // the final byte is always followed by a waiting word
  a_final_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("no word after the final byte");

endmodule

bind source_text_tokenizer stt_checker u_checker (.*);

/* verif/source_text_tokenizer_test.sv */
// testbench for the source text tokenizer: scoreboard with its own token predictor, random texts
module source_text_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 214;

  localparam logic [7:0] SEPARATORS [12] = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
    CH_LBRACE, CH_RBRACE, CH_COMMA, CH_SEMI, CH_MINUS, CH_PLUS, CH_STAR, CH_PERCENT};
  localparam logic [7:0] OPERATORS [4] = '{CH_LT, CH_GT, CH_BANG, CH_EQ};
  localparam logic [7:0] COMMENT_FILL [4] = '{8'h61, CH_STAR, CH_NL, CH_SPACE};

  typedef enum logic [2:0] {
    LX_NORMAL, LX_OPWAIT, LX_SLASH, LX_LINECOM, LX_BLOCKCOM, LX_STRING
  } lex_mode_t;

  typedef struct {
    bit        kind;
    bit [7:0]  tok;
    bit        first;
    bit [23:0] line;
    bit [2:0]  code;
    bit        last;
  } tok_word_t;

  class tok_scoreboard;
    tok_word_t expected_q[$];
    tok_word_t step_q[$];
    lex_mode_t mode;
    bit        tok_open;
    bit        single_quote;
    bit        star;
    bit [23:0] line_no;
    bit [23:0] bracket_lines [STACK_DEPTH];
    int        depth;
    status_t   err_code;
    bit [23:0] err_line;
    int        errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode = LX_NORMAL;
      tok_open = 1'b0;
      single_quote = 1'b0;
      star = 1'b0;
      line_no = 24'd1;
      depth = 0;
      err_code = ST_OK;
      err_line = 24'd0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void emit(bit [7:0] b, bit first);
      tok_word_t w;
      w = '{1'b0, b, first, line_no, ST_OK, 1'b0};
      step_q.insert(step_q.size(), w);
    endfunction

    function void raise(status_t code, bit [23:0] ln);
      if (err_code == ST_OK) begin
        err_code = code;
        err_line = ln;
      end
    endfunction

    function void bump_line();
      if (line_no != LINE_MAX) line_no++;
    endfunction

    function void plain_byte(bit [7:0] c);
      case (c)
        CH_LPAREN, CH_LBRACK, CH_LBRACE: begin
          if (depth < STACK_DEPTH) begin
            bracket_lines[depth] = line_no;
            depth++;
          end else begin
            raise(ST_FULL, line_no);
          end
          emit(c, 1'b1);
          tok_open = 1'b0;
        end
        CH_RPAREN, CH_RBRACK, CH_RBRACE: begin
          if (depth == 0) raise(ST_UNMATCHED, line_no);
          else depth--;
          emit(c, 1'b1);
          tok_open = 1'b0;
        end
        CH_LT, CH_GT, CH_BANG, CH_EQ: begin
          emit(c, 1'b1);
          tok_open = 1'b0;
          mode = LX_OPWAIT;
        end
        CH_DQUOTE, CH_SQUOTE: begin
          emit(c, !tok_open);
          tok_open = 1'b1;
          single_quote = (c == CH_SQUOTE);
          mode = LX_STRING;
        end
        CH_SLASH: begin
          tok_open = 1'b0;
          mode = LX_SLASH;
        end
        CH_SPACE, CH_TAB: tok_open = 1'b0;
        CH_NL: begin
          tok_open = 1'b0;
          bump_line();
        end
        CH_COMMA, CH_SEMI, CH_MINUS, CH_PLUS, CH_STAR, CH_PERCENT: begin
          emit(c, 1'b1);
          tok_open = 1'b0;
        end
        default: begin
          emit(c, !tok_open);
          tok_open = 1'b1;
        end
      endcase
    endfunction

    function void note_input(bit [7:0] c, bit last);
      status_t   code;
      bit [23:0] ln;
      tok_word_t w;
      step_q.delete();
      case (mode)
        LX_OPWAIT: begin
          mode = LX_NORMAL;
          if (c == CH_EQ) emit(c, 1'b0);
          else plain_byte(c);
        end
        LX_SLASH: begin
          if (c == CH_SLASH) begin
            mode = LX_LINECOM;
          end else if (c == CH_STAR) begin
            mode = LX_BLOCKCOM;
            star = 1'b1;
          end else begin
            mode = LX_NORMAL;
            emit(CH_SLASH, 1'b1);
            plain_byte(c);
          end
        end
        LX_LINECOM: begin
          if (c == CH_NL) begin
            bump_line();
            mode = LX_NORMAL;
          end
        end
        LX_BLOCKCOM: begin
          if (star && c == CH_SLASH) begin
            mode = LX_NORMAL;
            star = 1'b0;
          end else begin
            star = (c == CH_STAR);
            if (c == CH_NL) bump_line();
          end
        end
        LX_STRING: begin
          if (c == CH_NL) begin
            raise(ST_STRING, line_no);
            mode = LX_NORMAL;
            tok_open = 1'b0;
            plain_byte(c);
          end else if (c == (single_quote ? CH_SQUOTE : CH_DQUOTE)) begin
            emit(c, 1'b0);
            tok_open = 1'b0;
            mode = LX_NORMAL;
          end else begin
            emit(c, 1'b0);
          end
        end
        default: begin
          mode = LX_NORMAL;
          plain_byte(c);
        end
      endcase
      if (last) begin
        code = err_code;
        ln = err_line;
        if (code == ST_OK) begin
          ln = line_no;
          if (mode == LX_STRING) begin
            code = ST_STRING;
          end else if (mode != LX_NORMAL) begin
            code = ST_PENDING;
          end else if (depth > 0) begin
            code = ST_UNCLOSED;
            ln = bracket_lines[depth-1];
          end
        end
        w = '{1'b1, 8'h00, 1'b0, ln, code, 1'b0};
        step_q.insert(step_q.size(), w);
        clear();
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
      foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_output(logic [39:0] data, logic [0:0] user, logic last);
      tok_word_t want;
      if (expected_q.size() == 0) begin
        $error("word with nothing expected: tdata %h tuser %b", data, user);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", 32'(want.kind), 32'(user[0]));
      compare_field("out_byte", 32'(want.tok), 32'(data[7:0]));
      compare_field("first_of_token", 32'(want.first), 32'(data[8]));
      compare_field("line_number", 32'(want.line), 32'(data[32:9]));
      compare_field("status", 32'(want.code), 32'(data[35:33]));
      compare_field("last_of_run", 32'(want.last), 32'(last));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  tok_scoreboard sb = new();
  logic [7:0] text_buf[$];
  int burst_left = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  int cycle_count = 0;

  source_text_tokenizer dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** source_text_tokenizer: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_output(m_tdata, m_tuser, m_tlast);
    end
  end

  // receiver: rotating stall styles, plus one long hold-off on request
  initial begin
    int rx_style;
    int style_left;
    rx_style = 0;
    style_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (style_left == 0) begin
          rx_style = $urandom_range(0, 3);
          style_left = $urandom_range(20, 150);
        end
        style_left--;
        case (rx_style)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_word(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  task automatic idle_sender();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic void add_byte(logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic void add_ident();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(48, 57)));
      else add_byte(8'($urandom_range(97, 122)));
    end
  endfunction

  function automatic void add_piece();
    int w;
    logic [7:0] q;
    w = $urandom_range(0, 99);
    if (w < 18) begin
      add_ident();
    end else if (w < 30) begin
      case ($urandom_range(0, 2))
        0: add_byte(CH_SPACE);
        1: add_byte(CH_TAB);
        default: add_byte(CH_NL);
      endcase
    end else if (w < 42) begin
      add_byte(OPERATORS[$urandom_range(0, 3)]);
      if ($urandom_range(0, 1)) add_byte(CH_EQ);
    end else if (w < 58) begin
      add_byte(SEPARATORS[$urandom_range(0, 11)]);
    end else if (w < 68) begin
      q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      add_byte(q);
      repeat ($urandom_range(0, 5)) add_byte(printable());
      if ($urandom_range(0, 5) == 0) add_byte(CH_NL);
      else if ($urandom_range(0, 5) != 0) add_byte(q);
    end else if (w < 75) begin
      add_str("//");
      repeat ($urandom_range(0, 6)) add_byte(printable());
      add_byte(CH_NL);
    end else if (w < 83) begin
      if ($urandom_range(0, 3) == 0) begin
        add_str("/*/");
      end else begin
        add_str("/*");
        repeat ($urandom_range(0, 6)) add_byte(COMMENT_FILL[$urandom_range(0, 3)]);
        add_str("*/");
      end
    end else if (w < 88) begin
      add_byte(CH_SLASH);
      add_ident();
    end else begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    int random_items;
    random_items = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // operator join, comment closed by its own star, close with nothing open
    add_str("x<=/*/y)");
    send_text();
    // byte extremes, quote joining a token, newline inside a string
    add_byte(8'h00);
    add_byte(8'hFF);
    add_str("'q\n(!/");
    send_text();
    // lone slash flushed before the next byte, unclosed bracket
    add_str("\t{\n=b/c");
    send_text();
    // comment left open at the end
    add_str("*/*a\n*");
    send_text();
    idle_sender();
    wait_drained();

    // bracket stack overflow
    repeat (66) add_byte(CH_LPAREN);
    add_byte(CH_RPAREN);
    send_text();

    // long receiver hold-off while the sender keeps going
    hold_req = 1'b1;
    no_gaps = 1'b1;
    while (text_buf.size() < 48) add_piece();
    random_items += text_buf.size();
    send_text();

    while (random_items < RANDOM_ITEMS) begin
      repeat ($urandom_range(2, 14)) add_piece();
      random_items += text_buf.size();
      no_gaps = ($urandom_range(0, 3) == 0);
      send_text();
      if ($urandom_range(0, 9) == 0) begin
        idle_sender();
        wait_drained();
      end
    end

    idle_sender();
    wait_drained();
    repeat (16) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** source_text_tokenizer: PASSED **");
    end else begin
      $display("** source_text_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule
